[sv/cfs_pkg.sv]
// Shared types, constants and the CRC helper of the chunked frame sender.
package cfs_pkg;

  localparam int FrameBytes   = 64;
  localparam int HeaderBytes  = 7;
  localparam int PayloadLimit = FrameBytes - HeaderBytes;
  localparam int TrailerBytes = 8;

  localparam int LenW  = 6;
  localparam int IdxW  = 4;
  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);

  localparam logic [IdxW-1:0] HdrLastIdx   = IdxW'(HeaderBytes - 1);
  localparam logic [IdxW-1:0] FinalLastIdx = IdxW'(HeaderBytes + TrailerBytes - 1);
  localparam logic [7:0]      TrailerLen   = 8'(TrailerBytes);
  localparam logic [31:0]     CrcInit      = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CmdStart   = 3'd0,
    CmdBegin   = 3'd1,
    CmdPayload = 3'd2,
    CmdTxDone  = 3'd3,
    CmdTxFail  = 3'd4,
    CmdCancel  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    RegPoly      = 3'd0,
    RegMarker    = 3'd1,
    RegVersion   = 3'd2,
    RegDataType  = 3'd3,
    RegFinalType = 3'd4
  } reg_e;

  typedef struct packed {
    logic [31:0] poly;
    logic [7:0]  marker;
    logic [7:0]  version;
    logic [7:0]  data_type;
    logic [7:0]  final_type;
  } cfg_t;

  // One unit of work for the back end: either a single word or a header burst.
  typedef struct packed {
    logic            is_header;
    logic            is_final;
    logic [7:0]      word_byte;
    logic            word_valid;
    logic            word_rej;
    logic            active;
    logic            failed;
    logic [7:0]      run;
    logic [15:0]     chunk;
    logic [LenW-1:0] len;
    logic [31:0]     size;
    logic [31:0]     crcx;
  } job_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       byte_valid;
    logic       last;
    logic       status;
    logic       active;
    logic       failed;
  } out_word_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? poly : 32'b0);
    end
    return c;
  endfunction

endpackage

[sv/chunked_frame_sender_crc32_core.sv]
// Top level of the chunked frame sender: register port, front end, job queue, back end.
//
//  Channel     | Direction | Handshake                      | Contents
//  ------------+-----------+--------------------------------+------------------------------
//  s_axis      | in        | s_axis_tvalid / s_axis_tready  | one command word
//  m_axis      | out       | m_axis_tvalid / m_axis_tready  | one result word, tlast ends item
//  apb         | in        | psel, penable, pwrite, pready  | configuration registers
//
// The front end takes one command word per cycle whenever the four-entry job queue has
// room; its state update, including the byte-wide CRC step, completes in that cycle.
// The back end emits one result word per cycle unless m_axis stalls: every command gives
// one word, except a begin-frame that is not rejected, which gives 7 header words (15 for
// the closing frame), so the output rate is set by the back end's word counter. With the
// pipe empty, a command's first word passes the job queue and the back end's job register
// before it reaches the output register. Reset is asynchronous and needs no clearing pass.
// A stall on m_axis fills the job queue, after which s_axis_tready drops.
module chunked_frame_sender_crc32_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, lowest bit up: run_id[7:0], total_size[39:8], payload_length[45:40],
  // data_byte[53:46], zero fill[55:54].
  input  logic [55:0] s_axis_tdata,
  // tuser: command[2:0].
  input  logic [2:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, lowest bit up: frame_byte[7:0], byte_valid[8], status[9],
  // transfer_active[10], failure_flag[11], zero fill[15:12].
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfs_pkg::*;

  cfg_t      cfg_q;
  logic      cfg_wr;
  reg_e      reg_idx;
  logic      in_accept;
  job_t      front_job, queue_job;
  logic      queue_full, queue_valid, queue_pop;
  out_word_t out_word;

  // Register file. Writes are only expected while the block is idle, so the back end
  // may read the header bytes straight from these registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly       <= 32'hEDB8_8320;
      cfg_q.marker     <= 8'd0;
      cfg_q.version    <= 8'd1;
      cfg_q.data_type  <= 8'd1;
      cfg_q.final_type <= 8'd2;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegPoly:      cfg_q.poly       <= pwdata;
        RegMarker:    cfg_q.marker     <= pwdata[7:0];
        RegVersion:   cfg_q.version    <= pwdata[7:0];
        RegDataType:  cfg_q.data_type  <= pwdata[7:0];
        RegFinalType: cfg_q.final_type <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPoly:      prdata = cfg_q.poly;
      RegMarker:    prdata = {24'b0, cfg_q.marker};
      RegVersion:   prdata = {24'b0, cfg_q.version};
      RegDataType:  prdata = {24'b0, cfg_q.data_type};
      RegFinalType: prdata = {24'b0, cfg_q.final_type};
      default:      prdata = '0;
    endcase
  end

  assign s_axis_tready = !queue_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  cfs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .poly_i           (cfg_q.poly),
    .accept_i         (in_accept),
    .command_i        (s_axis_tuser),
    .run_id_i         (s_axis_tdata[7:0]),
    .total_size_i     (s_axis_tdata[39:8]),
    .payload_length_i (s_axis_tdata[45:40]),
    .data_byte_i      (s_axis_tdata[53:46]),
    .job_o            (front_job)
  );

  cfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_job_i (front_job),
    .pop_i      (queue_pop),
    .full_o     (queue_full),
    .valid_o    (queue_valid),
    .pop_job_o  (queue_job)
  );

  cfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (queue_valid),
    .job_i       (queue_job),
    .job_pop_o   (queue_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (out_word)
  );

  assign m_axis_tdata = {4'b0, out_word.failed, out_word.active, out_word.status,
                         out_word.byte_valid, out_word.frame_byte};
  assign m_axis_tlast = out_word.last;

endmodule

[sv/cfs_queue.sv]
// Small job FIFO between the command front end and the word back end.
module cfs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfs_pkg::job_t push_job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output cfs_pkg::job_t pop_job_o
);
  import cfs_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o    = (count_q == (QPtrW+1)'(QueueDepth));
  assign valid_o   = (count_q != '0);
  assign pop_job_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[sv/cfs_front.sv]
// Command front end: holds the transfer state and turns each command into a job.
module cfs_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [31:0]              poly_i,
  input  logic                     accept_i,
  input  logic [2:0]               command_i,
  input  logic [7:0]               run_id_i,
  input  logic [31:0]              total_size_i,
  input  logic [cfs_pkg::LenW-1:0] payload_length_i,
  input  logic [7:0]               data_byte_i,
  output cfs_pkg::job_t            job_o
);
  import cfs_pkg::*;

  logic            sending_q, sending_d;
  logic [31:0]     offset_q, offset_d, size_q, size_d;
  logic [31:0]     ccrc_q, ccrc_d, pcrc_q, pcrc_d;
  logic [15:0]     chunk_q, chunk_d;
  logic [7:0]      run_q, run_d;
  logic            queued_q, queued_d, final_q, final_d;
  logic [LenW-1:0] plen_q, plen_d, left_q, left_d;
  logic            fail_q, fail_d;

  logic            clear, stop;
  logic [31:0]     rem;
  logic [LenW-1:0] len_a, len;
  job_t            job;
  cmd_e            cmd;

  assign cmd = cmd_e'(command_i);

  always_comb begin
    sending_d = sending_q;
    offset_d  = offset_q;
    size_d    = size_q;
    ccrc_d    = ccrc_q;
    pcrc_d    = pcrc_q;
    chunk_d   = chunk_q;
    run_d     = run_q;
    queued_d  = queued_q;
    final_d   = final_q;
    plen_d    = plen_q;
    left_d    = left_q;
    fail_d    = fail_q;
    clear     = 1'b0;
    stop      = 1'b0;
    job       = '0;

    rem   = size_q - offset_q;
    len_a = (rem < {{(32-LenW){1'b0}}, payload_length_i}) ? rem[LenW-1:0] : payload_length_i;
    len   = (int'(len_a) > PayloadLimit) ? LenW'(PayloadLimit) : len_a;

    unique case (cmd)
      CmdStart: begin
        if (!sending_q) begin
          sending_d = 1'b1;
          size_d    = total_size_i;
          run_d     = run_id_i;
          fail_d    = 1'b0;
          clear     = 1'b1;
        end else begin
          job.word_rej = 1'b1;
        end
      end
      CmdBegin: begin
        job.run   = run_q;
        job.chunk = chunk_q;
        if (!sending_q || queued_q) begin
          job.word_rej = 1'b1;
        end else if (offset_q < size_q) begin
          if (len == '0) begin
            job.word_rej = 1'b1;
          end else begin
            queued_d      = 1'b1;
            final_d       = 1'b0;
            plen_d        = len;
            left_d        = len;
            pcrc_d        = ccrc_q;
            job.is_header = 1'b1;
            job.len       = len;
          end
        end else begin
          // Closing frame: size and inverted CRC follow the header directly.
          queued_d      = 1'b1;
          final_d       = 1'b1;
          plen_d        = '0;
          left_d        = '0;
          pcrc_d        = ccrc_q;
          job.is_header = 1'b1;
          job.is_final  = 1'b1;
          job.size      = size_q;
          job.crcx      = ccrc_q ^ CrcInit;
        end
      end
      CmdPayload: begin
        if (sending_q && queued_q && !final_q && (left_q != '0)) begin
          pcrc_d         = crc_byte(pcrc_q, data_byte_i, poly_i);
          left_d         = left_q - 1'b1;
          job.word_byte  = data_byte_i;
          job.word_valid = 1'b1;
        end else begin
          job.word_rej = 1'b1;
        end
      end
      CmdTxDone: begin
        if (sending_q && queued_q && (left_q == '0)) begin
          queued_d = 1'b0;
          if (final_q) begin
            stop = 1'b1;
          end else begin
            offset_d = offset_q + {{(32-LenW){1'b0}}, plen_q};
            ccrc_d   = pcrc_q;
            chunk_d  = chunk_q + 16'd1;
          end
        end else begin
          job.word_rej = 1'b1;
        end
      end
      CmdTxFail: begin
        stop   = 1'b1;
        fail_d = 1'b1;
      end
      CmdCancel: begin
        stop = 1'b1;
      end
      default: begin
        job.word_rej = 1'b1;
      end
    endcase

    if (stop) begin
      sending_d = 1'b0;
      size_d    = '0;
      clear     = 1'b1;
    end
    if (clear) begin
      offset_d = '0;
      ccrc_d   = CrcInit;
      pcrc_d   = CrcInit;
      chunk_d  = '0;
      queued_d = 1'b0;
      final_d  = 1'b0;
      plen_d   = '0;
      left_d   = '0;
    end

    job.active = sending_d;
    job.failed = fail_d;
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      offset_q  <= '0;
      size_q    <= '0;
      ccrc_q    <= CrcInit;
      pcrc_q    <= CrcInit;
      chunk_q   <= '0;
      run_q     <= '0;
      queued_q  <= 1'b0;
      final_q   <= 1'b0;
      plen_q    <= '0;
      left_q    <= '0;
      fail_q    <= 1'b0;
    end else if (accept_i) begin
      sending_q <= sending_d;
      offset_q  <= offset_d;
      size_q    <= size_d;
      ccrc_q    <= ccrc_d;
      pcrc_q    <= pcrc_d;
      chunk_q   <= chunk_d;
      run_q     <= run_d;
      queued_q  <= queued_d;
      final_q   <= final_d;
      plen_q    <= plen_d;
      left_q    <= left_d;
      fail_q    <= fail_d;
    end
  end

endmodule

[sv/cfs_back.sv]
// Word back end: expands queued jobs into output words, one per cycle unless the output stalls.
module cfs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfs_pkg::cfg_t      cfg_i,
  input  logic               job_valid_i,
  input  cfs_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfs_pkg::out_word_t out_word_o
);
  import cfs_pkg::*;

  job_t            cur_q, cur_d;
  logic            cur_vld_q, cur_vld_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_vld_q, out_vld_d;
  out_word_t       out_q, out_d;
  out_word_t       word;
  logic            load, cur_end;
  logic [7:0]      hdr_byte;

  assign load    = !out_vld_q || out_ready_i;
  assign cur_end = cur_vld_q &&
                   (!cur_q.is_header || (idx_q == (cur_q.is_final ? FinalLastIdx : HdrLastIdx)));
  assign job_pop_o = job_valid_i && (!cur_vld_q || (load && cur_end));

  always_comb begin
    case (idx_q)
      4'd0:    hdr_byte = cfg_i.marker;
      4'd1:    hdr_byte = cfg_i.version;
      4'd2:    hdr_byte = cur_q.is_final ? cfg_i.final_type : cfg_i.data_type;
      4'd3:    hdr_byte = cur_q.run;
      4'd4:    hdr_byte = cur_q.chunk[7:0];
      4'd5:    hdr_byte = cur_q.chunk[15:8];
      4'd6:    hdr_byte = cur_q.is_final ? TrailerLen : {{(8-LenW){1'b0}}, cur_q.len};
      4'd7:    hdr_byte = cur_q.size[7:0];
      4'd8:    hdr_byte = cur_q.size[15:8];
      4'd9:    hdr_byte = cur_q.size[23:16];
      4'd10:   hdr_byte = cur_q.size[31:24];
      4'd11:   hdr_byte = cur_q.crcx[7:0];
      4'd12:   hdr_byte = cur_q.crcx[15:8];
      4'd13:   hdr_byte = cur_q.crcx[23:16];
      default: hdr_byte = cur_q.crcx[31:24];
    endcase

    word.active = cur_q.active;
    word.failed = cur_q.failed;
    if (cur_q.is_header) begin
      word.frame_byte = hdr_byte;
      word.byte_valid = 1'b1;
      word.status     = 1'b0;
      word.last       = cur_end;
    end else begin
      word.frame_byte = cur_q.word_byte;
      word.byte_valid = cur_q.word_valid;
      word.status     = cur_q.word_rej;
      word.last       = 1'b1;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    idx_d     = idx_q;
    cur_vld_d = cur_vld_q;
    cur_d     = cur_q;
    if (load) begin
      out_vld_d = cur_vld_q;
      out_d     = word;
      if (cur_vld_q) begin
        idx_d = cur_end ? '0 : idx_q + 1'b1;
        if (cur_end) begin
          cur_vld_d = 1'b0;
        end
      end
    end
    if (job_pop_o) begin
      cur_d     = job_i;
      cur_vld_d = 1'b1;
      idx_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      cur_vld_q <= cur_vld_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    cur_q <= cur_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

[tb/tb.sv]
// Self-checking testbench for the chunked frame sender with CRC-32.
`timescale 1ns / 1ps

module tb;
  import cfs_pkg::*;

  // Command codes that the block must reject.
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  // This pause covers the time a word needs to come out, with margin.
  localparam int SettleCycles = 8;
  // Length of the deliberate hold-off on the result side.
  localparam int HoldCycles   = 300;

  // One command word as the source offers it. When "typed" is set, the expected
  // reply is written in the row itself instead of coming from the predictor.
  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  rid;
    logic [31:0] size;
    logic [5:0]  plen;
    logic [7:0]  dbyte;
    bit          typed;
    bit          t_status;
    bit          t_active;
    bit          t_failed;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata, lowest bit up: run_id, total_size, payload_length, data_byte, zero fill.
  logic [55:0] s_axis_tdata = '0;
  // tuser: command.
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata, lowest bit up: frame_byte, byte_valid, status, transfer_active,
  // failure_flag, zero fill.
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chunked_frame_sender_crc32_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs; the slowest correct run ends well before it.
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the sender's own progress and register copy, kept in step
  // with every command word that the block accepts.
  // ---------------------------------------------------------------------------
  cfg_t        regs;
  bit          busy;
  logic [31:0] sent_bytes;
  logic [31:0] set_size;
  logic [31:0] crc_done;
  logic [31:0] crc_open;
  logic [15:0] chunk_idx;
  logic [7:0]  run_tag;
  bit          frame_open;
  bit          open_is_final;
  logic [5:0]  open_len;
  logic [5:0]  open_left;
  bit          fail_seen;
  bit          last_rejected;

  // Result words that the block still owes, oldest first.
  out_word_t   owed_words[$];

  // Run statistics and error bookkeeping.
  int          errors = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          closed_runs = 0;
  int          payload_bytes = 0;
  int          rejections = 0;
  int          stalled_cycles = 0;

  // Test-flow control shared with the result side.
  bit          want_hold = 1'b0;

  // Reflected CRC update, one data bit per shift: the incoming bit is folded
  // into the feedback instead of being XORed into the register up front.
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = (c >> 1) ^ (fb ? regs.poly : 32'h0);
    end
    return c;
  endfunction

  function automatic void emit(input logic [7:0] b, input bit v, input bit l, input bit r);
    out_word_t w;
    w.frame_byte = v ? b : 8'h00;
    w.byte_valid = v;
    w.last       = l;
    w.status     = r;
    w.active     = busy;
    w.failed     = fail_seen;
    owed_words.push_back(w);
  endfunction

  function automatic void clear_progress();
    sent_bytes    = '0;
    crc_done      = CrcInit;
    crc_open      = CrcInit;
    chunk_idx     = '0;
    frame_open    = 1'b0;
    open_is_final = 1'b0;
    open_len      = '0;
    open_left     = '0;
  endfunction

  function automatic void stop_run();
    busy     = 1'b0;
    set_size = '0;
    clear_progress();
  endfunction

  // Works out the reply words of one accepted command and advances the state.
  function automatic void predict_command(input cmd_row_t it);
    logic [7:0]  hdr [0:14];
    logic [31:0] left;
    logic [31:0] len;
    logic [31:0] fcs;
    int          n;
    bit          ok;
    ok = 1'b0;
    n  = HeaderBytes;
    case (it.cmd)
      CmdStart: begin
        if (!busy) begin
          busy      = 1'b1;
          set_size  = it.size;
          run_tag   = it.rid;
          fail_seen = 1'b0;
          clear_progress();
          emit(8'h00, 1'b0, 1'b1, 1'b0);
          ok = 1'b1;
        end
      end
      CmdBegin: begin
        if (busy && !frame_open) begin
          hdr[0] = regs.marker;
          hdr[1] = regs.version;
          hdr[3] = run_tag;
          hdr[4] = chunk_idx[7:0];
          hdr[5] = chunk_idx[15:8];
          if (sent_bytes < set_size) begin
            // A data frame carries what was offered, cut to what is left of
            // the data set and to what fits after the header.
            left = set_size - sent_bytes;
            len  = {26'b0, it.plen};
            if (len > left) len = left;
            if (len > PayloadLimit) len = PayloadLimit;
            if (len != 0) begin
              hdr[2]        = regs.data_type;
              hdr[6]        = len[7:0];
              frame_open    = 1'b1;
              open_is_final = 1'b0;
              open_len      = len[5:0];
              open_left     = len[5:0];
              crc_open      = crc_done;
              ok            = 1'b1;
            end
          end else begin
            // Closing frame: size and inverted CRC, both little endian.
            fcs    = ~crc_done;
            hdr[2] = regs.final_type;
            hdr[6] = TrailerLen;
            for (int i = 0; i < 4; i++) begin
              hdr[HeaderBytes + i]     = set_size[8*i +: 8];
              hdr[HeaderBytes + 4 + i] = fcs[8*i +: 8];
            end
            n             = HeaderBytes + TrailerBytes;
            frame_open    = 1'b1;
            open_is_final = 1'b1;
            open_len      = '0;
            open_left     = '0;
            crc_open      = crc_done;
            ok            = 1'b1;
          end
          if (ok) begin
            for (int i = 0; i < n; i++) emit(hdr[i], 1'b1, i == n - 1, 1'b0);
          end
        end
      end
      CmdPayload: begin
        if (busy && frame_open && !open_is_final && open_left != 0) begin
          crc_open  = crc_step(crc_open, it.dbyte);
          open_left = open_left - 1'b1;
          emit(it.dbyte, 1'b1, 1'b1, 1'b0);
          payload_bytes++;
          ok = 1'b1;
        end
      end
      CmdTxDone: begin
        if (busy && frame_open && open_left == 0) begin
          frame_open = 1'b0;
          if (open_is_final) begin
            stop_run();
            closed_runs++;
          end else begin
            sent_bytes = sent_bytes + open_len;
            crc_done   = crc_open;
            chunk_idx  = chunk_idx + 1'b1;
          end
          emit(8'h00, 1'b0, 1'b1, 1'b0);
          ok = 1'b1;
        end
      end
      CmdTxFail: begin
        stop_run();
        fail_seen = 1'b1;
        emit(8'h00, 1'b0, 1'b1, 1'b0);
        ok = 1'b1;
      end
      CmdCancel: begin
        stop_run();
        emit(8'h00, 1'b0, 1'b1, 1'b0);
        ok = 1'b1;
      end
      default: ;
    endcase
    if (!ok) begin
      emit(8'h00, 1'b0, 1'b1, 1'b1);
      rejections++;
    end
    last_rejected = !ok;
  endfunction

  function automatic cmd_row_t make_row(input logic [2:0] cmd, input logic [7:0] rid,
                                        input logic [31:0] size, input logic [5:0] plen,
                                        input logic [7:0] dbyte, input bit typed,
                                        input bit st, input bit act, input bit fl);
    cmd_row_t r;
    r.cmd      = cmd;
    r.rid      = rid;
    r.size     = size;
    r.plen     = plen;
    r.dbyte    = dbyte;
    r.typed    = typed;
    r.t_status = st;
    r.t_active = act;
    r.t_failed = fl;
    return r;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Builds the next random command. Most words continue a well-formed transfer
  // (start, begin, the payload bytes, transmit complete, closing frame), the
  // rest is noise: any code, aborts, and out-of-order commands.
  function automatic cmd_row_t next_random();
    cmd_row_t r;
    int       pick;
    r = make_row(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom,
                 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), 1'b0, 0, 0, 0);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      return r;
    end
    if (pick < 14) begin
      r.cmd = pick[0] ? CmdCancel : CmdTxFail;
      return r;
    end
    if (!busy) begin
      r.cmd = CmdStart;
      pick  = $urandom_range(0, 9);
      if (pick < 7)       r.size = $urandom_range(1, 160);
      else if (pick == 7) r.size = 32'h0;
      else if (pick == 8) r.size = $urandom_range(161, 600);
    end else if (!frame_open) begin
      r.cmd = CmdBegin;
      pick  = $urandom_range(0, 19);
      if (pick < 17)       r.plen = 6'($urandom_range(1, PayloadLimit));
      else if (pick == 17) r.plen = 6'd0;
      else                 r.plen = 6'($urandom_range(PayloadLimit + 1, 63));
    end else if (!open_is_final && open_left != 0) begin
      r.cmd = CmdPayload;
    end else begin
      r.cmd = CmdTxDone;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side. A word is offered at a rising edge and counts as taken at the
  // first later edge that sees tready high; the predictor runs right then.
  // ---------------------------------------------------------------------------
  task automatic send_command(input cmd_row_t it);
    out_word_t fixed;
    int        gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {2'b00, it.dbyte, it.plen, it.size, it.rid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_in++;
    predict_command(it);
    if (it.typed) begin
      // Rows with a written-in reply only ever expect a single status word.
      owed_words.delete(owed_words.size() - 1);
      fixed.frame_byte = 8'h00;
      fixed.byte_valid = 1'b0;
      fixed.last       = 1'b1;
      fixed.status     = it.t_status;
      fixed.active     = it.t_active;
      fixed.failed     = it.t_failed;
      owed_words.push_back(fixed);
    end
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random traffic, mostly well-formed, until n words have been taken with effect.
  task automatic run_random(input int n);
    int done;
    done = 0;
    while (done < n) begin
      send_command(next_random());
      if (!last_rejected) done++;
    end
  endtask

  // Lets every owed word come out, then waits out the settle pause for anything that
  // should not be there, so that the block is idle for register writes.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Register port: setup then access for the write, and a read back that is
  // checked against the value just written.
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegPoly:      regs.poly       = val;
      RegMarker:    regs.marker     = val[7:0];
      RegVersion:   regs.version    = val[7:0];
      RegDataType:  regs.data_type  = val[7:0];
      RegFinalType: regs.final_type = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata != val) begin
      errors++;
      if (errors <= 10)
        $display("Register %0d reads back %h, written %h", idx, prdata, val);
    end
  endtask

  task automatic cfg_all(input logic [31:0] poly, input logic [7:0] marker,
                         input logic [7:0] version, input logic [7:0] dtype,
                         input logic [7:0] ftype);
    cfg_write(RegPoly, poly);
    cfg_write(RegMarker, {24'h0, marker});
    cfg_write(RegVersion, {24'h0, version});
    cfg_write(RegDataType, {24'h0, dtype});
    cfg_write(RegFinalType, {24'h0, ftype});
  endtask

  // ---------------------------------------------------------------------------
  // Result side. tready follows its own random pattern; once the main flow asks
  // for it, tready stays low for a long stretch so that the job queue fills and
  // the command input stalls while the source keeps offering words.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (want_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        want_hold = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Every word taken from the result stream is checked against the oldest one owed.
  out_word_t got;
  out_word_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !s_axis_tready) stalled_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        got.frame_byte = m_axis_tdata[7:0];
        got.byte_valid = m_axis_tdata[8];
        got.status     = m_axis_tdata[9];
        got.active     = m_axis_tdata[10];
        got.failed     = m_axis_tdata[11];
        got.last       = m_axis_tlast;
        if (owed_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected result word %h last %b", m_axis_tdata, m_axis_tlast);
        end else begin
          want = owed_words.pop_front();
          if (got.frame_byte !== want.frame_byte || got.byte_valid !== want.byte_valid ||
              got.last !== want.last || got.status !== want.status ||
              got.active !== want.active || got.failed !== want.failed) begin
            errors++;
            if (errors <= 10)
              $display({"Word %0d: expected byte %h valid %b last %b status %b active %b ",
                        "failed %b, got byte %h valid %b last %b status %b active %b ",
                        "failed %b"}, words_out,
                       want.frame_byte, want.byte_valid, want.last, want.status,
                       want.active, want.failed, got.frame_byte, got.byte_valid,
                       got.last, got.status, got.active, got.failed);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main flow.
  // ---------------------------------------------------------------------------
  cmd_row_t plan[$];

  initial begin : main_flow
    // State after reset, registers at their reset values.
    regs.poly       = 32'hEDB8_8320;
    regs.marker     = 8'h00;
    regs.version    = 8'h01;
    regs.data_type  = 8'h01;
    regs.final_type = 8'h02;
    run_tag         = 8'h00;
    fail_seen       = 1'b0;
    stop_run();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Idle commands, both spare codes, aborts while idle, a start
    // with all-ones id and size, a start while busy, an oversized offer that gets
    // cut to the frame limit, begin while a frame is queued, transmit complete
    // with payload missing, an empty data set that goes straight to the closing
    // frame, a payload byte against the closing frame, a zero-length offer, an
    // offer longer than the rest of the data, an extra payload byte, and a full
    // short transfer through its closing frame.
    plan.push_back(make_row(CmdPayload, 8'h00, 32'h0, 6'd0,  8'h00, 1, 1, 0, 0));
    plan.push_back(make_row(CmdBegin,   8'h00, 32'h0, 6'd0,  8'h00, 1, 1, 0, 0));
    plan.push_back(make_row(CmdTxDone,  8'h00, 32'h0, 6'd0,  8'h00, 1, 1, 0, 0));
    plan.push_back(make_row(CmdSpare6,  8'h00, 32'h0, 6'd0,  8'h00, 1, 1, 0, 0));
    plan.push_back(make_row(CmdSpare7,  8'hFF, 32'hFFFF_FFFF, 6'd63, 8'hFF, 1, 1, 0, 0));
    plan.push_back(make_row(CmdCancel,  8'h00, 32'h0, 6'd0,  8'h00, 1, 0, 0, 0));
    plan.push_back(make_row(CmdTxFail,  8'h00, 32'h0, 6'd0,  8'h00, 1, 0, 0, 1));
    plan.push_back(make_row(CmdStart,   8'hFF, 32'hFFFF_FFFF, 6'd0, 8'h00, 1, 0, 1, 0));
    plan.push_back(make_row(CmdStart,   8'h00, 32'h0, 6'd0,  8'h00, 1, 1, 1, 0));
    plan.push_back(make_row(CmdBegin,   8'h00, 32'h0, 6'd63, 8'h00, 0, 0, 0, 0));
    plan.push_back(make_row(CmdBegin,   8'h00, 32'h0, 6'd5,  8'h00, 1, 1, 1, 0));
    plan.push_back(make_row(CmdPayload, 8'h00, 32'h0, 6'd0,  8'hFF, 0, 0, 0, 0));
    plan.push_back(make_row(CmdTxDone,  8'h00, 32'h0, 6'd0,  8'h00, 1, 1, 1, 0));
    plan.push_back(make_row(CmdCancel,  8'h00, 32'h0, 6'd0,  8'h00, 1, 0, 0, 0));
    plan.push_back(make_row(CmdStart,   8'h00, 32'h0, 6'd0,  8'h00, 1, 0, 1, 0));
    plan.push_back(make_row(CmdBegin,   8'h00, 32'h0, 6'd9,  8'h00, 0, 0, 0, 0));
    plan.push_back(make_row(CmdPayload, 8'h00, 32'h0, 6'd0,  8'h00, 1, 1, 1, 0));
    plan.push_back(make_row(CmdTxDone,  8'h00, 32'h0, 6'd0,  8'h00, 1, 0, 0, 0));
    plan.push_back(make_row(CmdStart,   8'hA5, 32'd3, 6'd0,  8'h00, 1, 0, 1, 0));
    plan.push_back(make_row(CmdBegin,   8'h00, 32'h0, 6'd0,  8'h00, 1, 1, 1, 0));
    plan.push_back(make_row(CmdBegin,   8'h00, 32'h0, 6'd5,  8'h00, 0, 0, 0, 0));
    plan.push_back(make_row(CmdPayload, 8'h00, 32'h0, 6'd0,  8'h00, 0, 0, 0, 0));
    plan.push_back(make_row(CmdPayload, 8'h00, 32'h0, 6'd0,  8'hFF, 0, 0, 0, 0));
    plan.push_back(make_row(CmdPayload, 8'h00, 32'h0, 6'd0,  8'h5A, 0, 0, 0, 0));
    plan.push_back(make_row(CmdPayload, 8'h00, 32'h0, 6'd0,  8'h11, 1, 1, 1, 0));
    plan.push_back(make_row(CmdTxDone,  8'h00, 32'h0, 6'd0,  8'h00, 1, 0, 1, 0));
    plan.push_back(make_row(CmdBegin,   8'h00, 32'h0, 6'd0,  8'h00, 0, 0, 0, 0));
    plan.push_back(make_row(CmdTxDone,  8'h00, 32'h0, 6'd0,  8'h00, 1, 0, 0, 0));
    foreach (plan[i]) send_command(plan[i]);
    drain();

    // All-ones polynomial and alternating byte extremes. The long hold-off on
    // the result side happens early in this phase.
    cfg_all(32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
    want_hold = 1'b1;
    run_random(110);
    drain();

    // Zero polynomial (the CRC then only shifts) and the opposite extremes.
    cfg_all(32'h0000_0000, 8'h00, 8'hFF, 8'h00, 8'hFF);
    run_random(110);
    drain();

    // Another reflected polynomial and random header bytes.
    cfg_all(32'h82F6_3B78, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random(110);
    drain();

    // Back to the reset values for a last stretch of random traffic.
    cfg_all(32'hEDB8_8320, 8'h00, 8'h01, 8'h01, 8'h02);
    run_random(110);
    drain();

    if (owed_words.size() != 0) begin
      errors++;
      $display("%0d result words never arrived", owed_words.size());
    end
    $display("Run took %0d command words and checked %0d result words: %0d transfers closed,",
             words_in, words_out, closed_runs);
    $display("%0d payload bytes, %0d rejections, %0d input stall cycles.",
             payload_bytes, rejections, stalled_cycles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
